@@ hdl/cdq_pkg.sv @@
// shared types and constants for the circular deque
package cdq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ACTION_W     = 3;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);

    typedef enum logic [ACTION_W-1:0] {
        ACT_LIST       = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic listing;
        logic empty;
        logic full;
    } t_back_stat;

endpackage

@@ hdl/cdq_front.sv @@
// front end: accepts items, drops undefined actions, forwards commands
module cdq_front
    import cdq_pkg::*;
(
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic signed [VALUE_W-1:0]  s_axis_tdata,   // value
    input  logic [ACTION_W-1:0]        s_axis_tuser,   // action
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output t_cmd                       o_q_cmd
);

    logic legal;

    always_comb begin
        case (s_axis_tuser)
            ACT_LIST, ACT_PUSH_FRONT, ACT_PUSH_BACK,
            ACT_POP_FRONT, ACT_POP_BACK, ACT_CLEAR: legal = 1'b1;
            default: legal = 1'b0;
        endcase
    end

    assign s_axis_tready  = !i_q_full;
    assign o_q_push       = s_axis_tvalid && !i_q_full && legal;
    assign o_q_cmd.action = t_action'(s_axis_tuser);
    assign o_q_cmd.value  = s_axis_tdata;

endmodule

@@ hdl/cdq_queue.sv @@
// short command queue between front end and execution unit
module cdq_queue
    import cdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd               r_entry [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_fill;

    assign o_full  = r_fill == (Q_PTR_W+1)'(Q_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_cmd   = r_entry[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (Q_PTR_W+1)'(1);
                2'b01:   r_fill <= r_fill - (Q_PTR_W+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ hdl/cdq_back.sv @@
// execution unit: ring store, head and count, list walk, result registers
module cdq_back
    import cdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  t_cmd                       i_q_cmd,
    output logic                       o_q_pop,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic signed [VALUE_W-1:0]  m_axis_tdata,   // data
    output logic [STATUS_W-1:0]        m_axis_tuser,   // status
    output logic                       m_axis_tlast,
    output t_back_stat                 o_stat
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h, input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(h) + SW'(off);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rd_data;

    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_listing, n_listing;
    logic [CW-1:0] r_off, n_off;

    logic          r_b_valid;
    t_status       r_b_status;
    logic          r_b_use_mem;
    logic          r_b_last;

    logic                      r_out_valid;
    t_status                   r_out_status;
    logic signed [VALUE_W-1:0] r_out_data;
    logic                      r_out_last;

    logic          b_move;
    logic          a_ready;
    logic          a_fire;
    t_status       a_status;
    logic          a_use_mem;
    logic          a_last;
    logic          rd_en;
    logic [CW-1:0] rd_off;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          empty;
    logic          full;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [CW-1:0] off_inc;

    assign empty    = r_count == '0;
    assign full     = r_count == CW'(CAPACITY);
    assign head_dec = (r_head == '0) ? IW'(CAPACITY - 1) : r_head - IW'(1);
    assign head_inc = (r_head == IW'(CAPACITY - 1)) ? '0 : r_head + IW'(1);
    assign off_inc  = r_off + CW'(1);
    assign b_move   = r_b_valid && (!r_out_valid || m_axis_tready);
    assign a_ready  = !r_b_valid || b_move;
    assign rd_addr  = slot_of(r_head, rd_off);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_listing = r_listing;
        n_off     = r_off;
        o_q_pop   = 1'b0;
        a_fire    = 1'b0;
        a_status  = ST_OK;
        a_use_mem = 1'b0;
        a_last    = 1'b1;
        rd_en     = 1'b0;
        rd_off    = '0;
        wr_en     = 1'b0;
        wr_addr   = slot_of(r_head, r_count);
        if (a_ready) begin
            if (r_listing) begin
                a_fire    = 1'b1;
                rd_en     = 1'b1;
                rd_off    = r_off;
                a_use_mem = 1'b1;
                a_last    = off_inc == r_count;
                n_off     = off_inc;
                if (a_last) begin
                    n_listing = 1'b0;
                end
            end else if (i_q_valid) begin
                a_fire  = 1'b1;
                o_q_pop = 1'b1;
                case (i_q_cmd.action)
                    ACT_LIST: begin
                        if (empty) begin
                            a_status = ST_EMPTY;
                        end else begin
                            rd_en     = 1'b1;
                            a_use_mem = 1'b1;
                            a_last    = r_count == CW'(1);
                            if (r_count != CW'(1)) begin
                                n_listing = 1'b1;
                                n_off     = CW'(1);
                            end
                        end
                    end
                    ACT_PUSH_FRONT: begin
                        if (full) begin
                            a_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = head_dec;
                            n_head  = head_dec;
                            n_count = r_count + CW'(1);
                        end
                    end
                    ACT_PUSH_BACK: begin
                        if (full) begin
                            a_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    ACT_POP_FRONT: begin
                        if (empty) begin
                            a_status = ST_EMPTY;
                        end else begin
                            rd_en     = 1'b1;
                            a_use_mem = 1'b1;
                            n_head    = head_inc;
                            n_count   = r_count - CW'(1);
                        end
                    end
                    ACT_POP_BACK: begin
                        if (empty) begin
                            a_status = ST_EMPTY;
                        end else begin
                            rd_en     = 1'b1;
                            rd_off    = r_count - CW'(1);
                            a_use_mem = 1'b1;
                            n_count   = r_count - CW'(1);
                        end
                    end
                    ACT_CLEAR: begin
                        if (empty) begin
                            a_status = ST_EMPTY;
                        end else begin
                            n_count = '0;
                        end
                    end
                    default: begin
                        a_fire = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_q_cmd.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_status  <= a_status;
            r_b_use_mem <= a_use_mem;
            r_b_last    <= a_last;
        end
        if (b_move) begin
            r_out_status <= r_b_status;
            r_out_data   <= r_b_use_mem ? r_rd_data : '0;
            r_out_last   <= r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_listing   <= 1'b0;
            r_off       <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_listing <= n_listing;
            r_off     <= n_off;
            if (a_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid  = r_out_valid;
    assign m_axis_tdata   = r_out_data;
    assign m_axis_tuser   = r_out_status;
    assign m_axis_tlast   = r_out_last;
    assign o_stat.listing = r_listing;
    assign o_stat.empty   = empty;
    assign o_stat.full    = full;

endmodule

@@ hdl/circular_deque_top.sv @@
// top level of the bounded double-ended queue
//
//  channel  dir  tdata         tuser          tlast
//  s_axis   in   value[31:0]   action[2:0]    -
//  m_axis   out  data[31:0]    status[1:0]    last of the item's results
//
// push, pop and clear: one item per cycle while the result side does not stall and no list walk runs, one result each
// list: one result per element (one when empty), one store read per element through the single read port
// a result passes the command queue, the result stage with the store read, and the output register
// reset clears head, count and all valid flags; store contents are left as they are
// each side stalls on its own, the command queue holds up to four items
module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic signed [VALUE_W-1:0]  s_axis_tdata,   // value
    input  logic [ACTION_W-1:0]        s_axis_tuser,   // action
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic signed [VALUE_W-1:0]  m_axis_tdata,   // data
    output logic [STATUS_W-1:0]        m_axis_tuser,   // status
    output logic                       m_axis_tlast
);

    logic       q_push;
    t_cmd       q_in;
    logic       q_full;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_pop;
    t_back_stat stat;

    cdq_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in)
    );

    cdq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    cdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_stat        (stat)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue pushed while full");

    a_list_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.listing |-> !stat.empty)
        else $error("list walk running on an empty store");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_cmd.action == ACT_CLEAR) |=> stat.empty)
        else $error("store not empty after clear");

endmodule

@@ bench/deque_checker.sv @@
// checker for the deque: predicts results of each accepted item and compares them
`timescale 1ns / 100ps

module deque_checker
    import cdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic signed [VALUE_W-1:0]  s_axis_tdata,   // value
    input  logic [ACTION_W-1:0]        s_axis_tuser,   // action
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic signed [VALUE_W-1:0]  m_axis_tdata,   // data
    input  logic [STATUS_W-1:0]        m_axis_tuser,   // status
    input  logic                       m_axis_tlast,
    output int                         o_outstanding,
    output int                         o_mismatches
);

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] data;
        logic                      last;
    } t_deque_result;

    t_deque_result             pending_results[$];
    logic signed [VALUE_W-1:0] shadow_ring[CAPACITY];
    int                        shadow_head;
    int                        shadow_count;
    int                        mismatches;
    int                        results_seen;

    assign o_mismatches = mismatches;

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got %h want %h", results_seen, field, got, want);
    endtask

    task automatic add_result(input t_status status, input logic signed [VALUE_W-1:0] data,
                              input logic last);
        t_deque_result r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        pending_results.push_back(r);
    endtask

    task automatic apply_action(input logic [ACTION_W-1:0] act,
                                input logic signed [VALUE_W-1:0] val);
        int i;
        logic signed [VALUE_W-1:0] popped;
        case (act)
            ACT_LIST: begin
                if (shadow_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        add_result(ST_OK, shadow_ring[(shadow_head + i) % CAPACITY],
                                   i == shadow_count - 1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (shadow_count >= CAPACITY) begin
                    add_result(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_head = (shadow_head == 0) ? CAPACITY - 1 : shadow_head - 1;
                    shadow_ring[shadow_head] = val;
                    shadow_count++;
                    add_result(ST_OK, '0, 1'b1);
                end
            end
            ACT_PUSH_BACK: begin
                if (shadow_count >= CAPACITY) begin
                    add_result(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_ring[(shadow_head + shadow_count) % CAPACITY] = val;
                    shadow_count++;
                    add_result(ST_OK, '0, 1'b1);
                end
            end
            ACT_POP_FRONT: begin
                if (shadow_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    popped = shadow_ring[shadow_head];
                    shadow_head = (shadow_head + 1) % CAPACITY;
                    shadow_count--;
                    add_result(ST_OK, popped, 1'b1);
                end
            end
            ACT_POP_BACK: begin
                if (shadow_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    popped = shadow_ring[(shadow_head + shadow_count - 1) % CAPACITY];
                    shadow_count--;
                    add_result(ST_OK, popped, 1'b1);
                end
            end
            ACT_CLEAR: begin
                if (shadow_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    shadow_count = 0;
                    add_result(ST_OK, '0, 1'b1);
                end
            end
            default: begin
                // undefined actions are dropped without a result
            end
        endcase
    endtask

    task automatic check_result();
        t_deque_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report("unexpected result, data", m_axis_tdata, '0);
        end else begin
            want = pending_results.pop_front();
            if (m_axis_tuser !== want.status)
                report("status", m_axis_tuser, want.status);
            if (m_axis_tdata !== want.data)
                report("data", m_axis_tdata, want.data);
            if (m_axis_tlast !== want.last)
                report("last", m_axis_tlast, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_results.delete();
            shadow_head  = 0;
            shadow_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                apply_action(s_axis_tuser, s_axis_tdata);
        end
        o_outstanding <= pending_results.size();
    end

endmodule

@@ bench/tb.sv @@
// testbench top: drives directed and random deque traffic and reports the verdict
`timescale 1ns / 100ps

module tb;
    import cdq_pkg::*;

    localparam int                CAP          = CAPACITY_DEF;
    localparam int                MAX_GAP      = 5;
    localparam int                IDLE_LIMIT   = 5000;
    localparam int                DRAIN_CYCLES = 20;
    localparam int                FILL_PUSHES  = CAP + 4;
    localparam int                PHASE_ITEMS  = 40;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
    localparam int                MODE_GROW    = 0;
    localparam int                MODE_SHRINK  = 1;
    localparam int                MODE_MIXED   = 2;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic signed [VALUE_W-1:0] s_axis_tdata  = '0;
    logic [ACTION_W-1:0]       s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic signed [VALUE_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]       m_axis_tuser;
    logic                      m_axis_tlast;

    int outstanding;
    int mismatches;
    int sink_stall = 0;
    bit calm       = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    circular_deque_top #(.CAPACITY(CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    deque_checker #(.CAPACITY(CAP)) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    // result side: random stall after a taken result, none while calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (!calm && $urandom_range(0, MAX_GAP) != 0) begin
                m_axis_tready <= 1'b0;
                sink_stall    <= $urandom_range(1, MAX_GAP);
            end
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            if (sink_stall == 1)
                m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // hold off the sender until every expected result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 35)      return ACT_PUSH_FRONT;
                else if (r < 70) return ACT_PUSH_BACK;
                else if (r < 78) return ACT_POP_FRONT;
                else if (r < 86) return ACT_POP_BACK;
                else if (r < 94) return ACT_LIST;
                else if (r < 96) return ACT_CLEAR;
            end
            MODE_SHRINK: begin
                if (r < 12)      return ACT_PUSH_FRONT;
                else if (r < 24) return ACT_PUSH_BACK;
                else if (r < 57) return ACT_POP_FRONT;
                else if (r < 90) return ACT_POP_BACK;
                else if (r < 94) return ACT_LIST;
                else if (r < 96) return ACT_CLEAR;
            end
            default: begin
                if (r < 22)      return ACT_PUSH_FRONT;
                else if (r < 44) return ACT_PUSH_BACK;
                else if (r < 64) return ACT_POP_FRONT;
                else if (r < 84) return ACT_POP_BACK;
                else if (r < 92) return ACT_LIST;
                else if (r < 96) return ACT_CLEAR;
            end
        endcase
        return (r < 98) ? ACT_UNDEF_LO : ACT_UNDEF_HI;
    endfunction

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int i;
        int phase;
        int mode;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, undefined actions, field extremes and index wrap
        send_item(ACT_LIST, '0);
        send_item(ACT_POP_FRONT, '0);
        send_item(ACT_POP_BACK, '0);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_UNDEF_LO, 32'h1234_5678);
        send_item(ACT_UNDEF_HI, 32'hffff_ffff);
        send_item(ACT_PUSH_FRONT, 32'h8000_0000);
        send_item(ACT_PUSH_BACK, 32'h7fff_ffff);
        send_item(ACT_PUSH_FRONT, 32'hffff_ffff);
        send_item(ACT_PUSH_BACK, 32'h0000_0000);
        send_item(ACT_LIST, 32'hffff_ffff);
        send_item(ACT_POP_FRONT, 32'hffff_ffff);
        send_item(ACT_POP_BACK, '0);
        send_item(ACT_POP_FRONT, '0);
        send_item(ACT_LIST, '0);
        send_item(ACT_PUSH_FRONT, 32'h5a5a_a5a5);
        send_item(ACT_PUSH_BACK, 32'ha5a5_5a5a);
        send_item(ACT_CLEAR, 32'hffff_ffff);
        send_item(ACT_LIST, '0);
        send_item(ACT_PUSH_BACK, 32'h0000_0001);
        send_item(ACT_POP_BACK, '0);
        drain();

        // fill past capacity, then list the full store
        calm = 1'b1;
        send_item(ACT_CLEAR, '0);
        for (i = 0; i < FILL_PUSHES; i++)
            send_item(($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                      pick_value());
        calm = 1'b0;
        send_item(ACT_LIST, $urandom());

        for (phase = 0; phase < 5; phase++) begin
            mode = (phase % 3 == 0) ? MODE_GROW : (phase % 3 == 1) ? MODE_SHRINK : MODE_MIXED;
            calm = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < 3)
                    drain();
                send_item(pick_action(mode), pick_value());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
